// ===== hdl/hqpm_pkg.sv =====
// Shared widths, register indexes and status codes of the deconvolution bin update.
`default_nettype none

package hqpm_pkg;

  localparam int unsigned DATA_W  = 32;
  // Widest numerator: 65-bit magnitude times 32-bit weight.
  localparam int unsigned NUM_W   = 97;
  // Quotient bits kept before the quotient is known to saturate the output.
  localparam int unsigned QUO_W   = 33;
  localparam int unsigned ADDR_W  = 3;

  localparam logic REG_WEIGHT    = 1'b0;
  localparam logic REG_TWO_TERMS = 1'b1;

  localparam logic [31:0] WEIGHT_RESET = 32'h0001_0000;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic signed [31:0] OUT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [31:0] in_re;
    logic [31:0] in_im;
    logic        neg_re;
    logic        neg_im;
    logic        zero;
    logic        big_re;
    logic        big_im;
  } side_t;

endpackage

`default_nettype wire

// ===== hdl/hqpm_deconv_bin_update.sv =====
// Top level: pipelined frequency-domain update of one deconvolution bin.
`default_nettype none

// One bin enters per clock and one result leaves per clock while the output
// is not stalled. The front end takes nine stages: capture, 32x32 products,
// two adder stages, sign split, 32x33 weight products, numerator recombination,
// denominator sum and the overflow check. A restoring divider follows with one
// stage per quotient bit (33 stages) and a final add and saturate register. A
// stall on the output holds the whole pipeline. The input stage still takes a
// beat while it is empty. Configuration registers must only be written while no
// beat is in flight.
module hqpm_deconv_bin_update
  import hqpm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // in_real, in_imag, kernel_real, kernel_imag, reg1_real, reg1_imag, reg2_real,
  // reg2_imag, weight1_real, weight1_imag, weight2_real, weight2_imag (32 bits each)
  input  wire logic [383:0]  s_axis_tdata,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // out_real [31:0], out_imag [63:32]
  output logic [63:0]        m_axis_tdata,
  // status [1:0]
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned DEN_W = 98 - FRAC_BITS;
  localparam int unsigned CMP_W = DEN_W + QUO_W;
  localparam int unsigned DIV_N = QUO_W;

  // Configuration registers.
  logic [31:0] weight_q;
  logic        two_terms_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= WEIGHT_RESET;
      two_terms_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WEIGHT) begin
        weight_q <= pwdata;
      end
      if (paddr[2] == REG_TWO_TERMS) begin
        two_terms_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_WEIGHT) begin
      prdata = weight_q;
    end else begin
      prdata = {31'd0, two_terms_q};
    end
  end

  // Pipeline control.
  logic en;
  logic ld0;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic vd_q [DIV_N+1];
  logic vo_q;

  assign en            = !vo_q || m_axis_tready;
  assign ld0           = en || !v0_q;
  assign s_axis_tready = ld0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
      for (int i = 0; i <= DIV_N; i++) begin
        vd_q[i] <= 1'b0;
      end
      vo_q <= 1'b0;
    end else begin
      if (ld0) begin
        v0_q <= s_axis_tvalid;
      end
      if (en) begin
        v1_q <= v0_q; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
        v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
        vd_q[0] <= v7_q;
        for (int i = 0; i < DIV_N; i++) begin
          vd_q[i+1] <= vd_q[i];
        end
        vo_q <= vd_q[DIV_N];
      end
    end
  end

  // Stage 0: capture, second term masked off in one-term mode.
  logic signed [31:0] kr_q, ki_q, r1r_q, r1i_q, r2r_q, r2i_q;
  logic signed [31:0] w1r_q, w1i_q, w2r_q, w2i_q;
  side_t s0_q;

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      s0_q        <= '{s_axis_tdata[31:0], s_axis_tdata[63:32],
                       1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      kr_q        <= s_axis_tdata[95:64];
      ki_q        <= s_axis_tdata[127:96];
      r1r_q       <= s_axis_tdata[159:128];
      r1i_q       <= s_axis_tdata[191:160];
      r2r_q       <= two_terms_q ? s_axis_tdata[223:192] : 32'd0;
      r2i_q       <= two_terms_q ? s_axis_tdata[255:224] : 32'd0;
      w1r_q       <= s_axis_tdata[287:256];
      w1i_q       <= s_axis_tdata[319:288];
      w2r_q       <= two_terms_q ? s_axis_tdata[351:320] : 32'd0;
      w2i_q       <= two_terms_q ? s_axis_tdata[383:352] : 32'd0;
    end
  end

  // Stage 1: products.
  logic signed [63:0] pkr_q, pki_q, pr1r_q, pr1i_q, pr2r_q, pr2i_q;
  logic signed [63:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q, pg_q, ph_q;
  side_t s1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= s0_q;
      pkr_q  <= kr_q * kr_q;
      pki_q  <= ki_q * ki_q;
      pr1r_q <= r1r_q * r1r_q;
      pr1i_q <= r1i_q * r1i_q;
      pr2r_q <= r2r_q * r2r_q;
      pr2i_q <= r2i_q * r2i_q;
      pa_q   <= w1r_q * r1r_q;
      pb_q   <= w1i_q * r1i_q;
      pc_q   <= w2r_q * r2r_q;
      pd_q   <= w2i_q * r2i_q;
      pe_q   <= w1i_q * r1r_q;
      pf_q   <= w1r_q * r1i_q;
      pg_q   <= w2i_q * r2r_q;
      ph_q   <= w2r_q * r2i_q;
    end
  end

  // Stage 2: pairwise sums. Squares are never negative.
  logic [63:0] kk2_q, rra_q, rrb_q;
  logic signed [64:0] nra_q, nrb_q, nia_q, nib_q;
  side_t s2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q  <= s1_q;
      kk2_q <= 64'(pkr_q) + 64'(pki_q);
      rra_q <= 64'(pr1r_q) + 64'(pr1i_q);
      rrb_q <= 64'(pr2r_q) + 64'(pr2i_q);
      nra_q <= 65'(pa_q) + 65'(pb_q);
      nrb_q <= 65'(pc_q) + 65'(pd_q);
      nia_q <= 65'(pe_q) - 65'(pf_q);
      nib_q <= 65'(pg_q) - 65'(ph_q);
    end
  end

  // Stage 3: full sums.
  logic [63:0] kk3_q;
  logic [64:0] rr3_q;
  logic signed [65:0] nre_q, nim_q;
  side_t s3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q  <= s2_q;
      kk3_q <= kk2_q;
      rr3_q <= 65'(rra_q) + 65'(rrb_q);
      nre_q <= 66'(nra_q) + 66'(nrb_q);
      nim_q <= 66'(nia_q) + 66'(nib_q);
    end
  end

  // Stage 4: sign and magnitude of the numerator.
  logic [63:0] kk4_q;
  logic [64:0] rr4_q, mre_q, mim_q;
  side_t s4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q        <= '{s3_q.in_re, s3_q.in_im, nre_q[65], nim_q[65],
                       1'b0, 1'b0, 1'b0};
      kk4_q       <= kk3_q;
      rr4_q       <= rr3_q;
      mre_q       <= nre_q[65] ? 65'(-nre_q) : 65'(nre_q);
      mim_q       <= nim_q[65] ? 65'(-nim_q) : 65'(nim_q);
    end
  end

  // Stage 5: weight partial products, 32 by 32 bits for the low halves and 33 by 32 for the high.
  logic [63:0] kk5_q;
  logic [63:0] lre_q, lim_q, lrr_q;
  logic [64:0] hre_q, him_q, hrr_q;
  side_t s5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q  <= s4_q;
      kk5_q <= kk4_q;
      lre_q <= mre_q[31:0] * weight_q;
      lim_q <= mim_q[31:0] * weight_q;
      lrr_q <= rr4_q[31:0] * weight_q;
      hre_q <= 65'(mre_q[64:32]) * 65'(weight_q);
      him_q <= 65'(mim_q[64:32]) * 65'(weight_q);
      hrr_q <= 65'(rr4_q[64:32]) * 65'(weight_q);
    end
  end

  // Stage 6: recombine the partial products.
  logic [63:0]      kk6_q;
  logic [NUM_W-1:0] numre6_q, numim6_q, lrr6_q;
  side_t s6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q     <= s5_q;
      kk6_q    <= kk5_q;
      numre6_q <= NUM_W'(lre_q) + {hre_q, 32'd0};
      numim6_q <= NUM_W'(lim_q) + {him_q, 32'd0};
      lrr6_q   <= NUM_W'(lrr_q) + {hrr_q, 32'd0};
    end
  end

  // Stage 7: denominator, with the low bits of the weight term dropped.
  logic [DEN_W-1:0] den7_q;
  logic [NUM_W-1:0] numre7_q, numim7_q;
  side_t s7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q     <= s6_q;
      den7_q   <= DEN_W'(kk6_q) + DEN_W'(lrr6_q >> FRAC_BITS);
      numre7_q <= numre6_q;
      numim7_q <= numim6_q;
    end
  end

  // Divider arrays; index 0 is loaded by the overflow check stage.
  logic [NUM_W-1:0] remre_q [DIV_N+1];
  logic [NUM_W-1:0] remim_q [DIV_N+1];
  logic [QUO_W-1:0] qre_q   [DIV_N+1];
  logic [QUO_W-1:0] qim_q   [DIV_N+1];
  logic [DEN_W-1:0] den_q   [DIV_N+1];
  side_t            sd_q    [DIV_N+1];

  logic [CMP_W-1:0] den_top;
  assign den_top = {den7_q, {QUO_W{1'b0}}};

  // Stage 8: a numerator at or above den * 2^33 saturates the output unless the denominator is zero.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0]        <= '{s7_q.in_re, s7_q.in_im, s7_q.neg_re, s7_q.neg_im,
                          (den7_q == '0),
                          (CMP_W'(numre7_q) >= den_top),
                          (CMP_W'(numim7_q) >= den_top)};
      den_q[0]       <= den7_q;
      remre_q[0]     <= numre7_q;
      remim_q[0]     <= numim7_q;
      qre_q[0]       <= '0;
      qim_q[0]       <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    localparam int unsigned BIT = DIV_N - 1 - k;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] rre_x, rim_x;
    logic             ge_re, ge_im;

    assign dsh   = CMP_W'(den_q[k]) << BIT;
    assign rre_x = CMP_W'(remre_q[k]);
    assign rim_x = CMP_W'(remim_q[k]);
    assign ge_re = rre_x >= dsh;
    assign ge_im = rim_x >= dsh;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sd_q[k+1]    <= sd_q[k];
        den_q[k+1]   <= den_q[k];
        remre_q[k+1] <= ge_re ? NUM_W'(rre_x - dsh) : remre_q[k];
        remim_q[k+1] <= ge_im ? NUM_W'(rim_x - dsh) : remim_q[k];
        qre_q[k+1]   <= qre_q[k] | (QUO_W'(ge_re) << BIT);
        qim_q[k+1]   <= qim_q[k] | (QUO_W'(ge_im) << BIT);
      end
    end
  end

  // Final stage: add to the input and saturate.
  side_t             sf;
  logic signed [34:0] sum_re, sum_im;
  logic signed [31:0] out_re_d, out_im_d;
  logic               sat_re, sat_im;
  logic [1:0]         status_d;
  logic [63:0]        data_q;
  logic [1:0]         user_q;

  assign sf = sd_q[DIV_N];

  always_comb begin
    sum_re = sf.neg_re ? 35'(signed'(sf.in_re)) - signed'({2'b00, qre_q[DIV_N]})
                       : 35'(signed'(sf.in_re)) + signed'({2'b00, qre_q[DIV_N]});
    sum_im = sf.neg_im ? 35'(signed'(sf.in_im)) - signed'({2'b00, qim_q[DIV_N]})
                       : 35'(signed'(sf.in_im)) + signed'({2'b00, qim_q[DIV_N]});
    sat_re = 1'b1;
    sat_im = 1'b1;
    if (sf.big_re || sum_re > 35'(OUT_MAX) || sum_re < 35'(OUT_MIN)) begin
      out_re_d = (sf.neg_re) ? OUT_MIN : OUT_MAX;
    end else begin
      out_re_d = sum_re[31:0];
      sat_re   = 1'b0;
    end
    if (sf.big_im || sum_im > 35'(OUT_MAX) || sum_im < 35'(OUT_MIN)) begin
      out_im_d = (sf.neg_im) ? OUT_MIN : OUT_MAX;
    end else begin
      out_im_d = sum_im[31:0];
      sat_im   = 1'b0;
    end
    if (sf.zero) begin
      out_re_d = sf.in_re;
      out_im_d = sf.in_im;
      status_d = STATUS_ZERO;
    end else if (sat_re || sat_im) begin
      status_d = STATUS_SAT;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= {out_im_d, out_re_d};
      user_q <= status_d;
    end
  end

  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tvalid = vo_q;

endmodule

`default_nettype wire

// ===== hdl/hqpm_checker.sv =====
// Port-level checks of the deconvolution bin update and their bind.
`default_nettype none

module hqpm_checker
  import hqpm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready
);

  // No result can be out right after reset: the pipeline is many stages deep.
  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_ZERO ||
                       m_axis_tuser == STATUS_SAT))
    else $error("unknown status code");

  // A saturated beat carries at least one clamped component.
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == STATUS_SAT) |->
      (m_axis_tdata[31:0] == OUT_MAX || m_axis_tdata[31:0] == OUT_MIN ||
       m_axis_tdata[63:32] == OUT_MAX || m_axis_tdata[63:32] == OUT_MIN))
    else $error("saturation status without a clamped value");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result beat changed");

endmodule

bind hqpm_deconv_bin_update hqpm_checker u_hqpm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

`default_nettype wire
